FILE: sv/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");

`endif

FILE: sv/clpl_pkg.sv
package clpl_pkg;
	localparam int NUM_CURVES = 6;
	localparam int SIZE_W = 16;
	localparam int TIME_W = 32;
	localparam int SEL_W = 3;
	localparam int STATUS_W = 2;
	localparam int PROD_W = SIZE_W + 1 + TIME_W + 1;
	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_TIME_FRAC_BITS = 16;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEL,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic mode;
		logic [SIZE_W-1:0] req_size;
		logic [SEL_W-1:0] curve_select;
		logic signed [TIME_W-1:0] prefill_pre_time;
		logic signed [TIME_W-1:0] prefill_proc_time;
		logic signed [TIME_W-1:0] prefill_post_time;
		logic signed [TIME_W-1:0] decode_pre_time;
		logic signed [TIME_W-1:0] decode_proc_time;
		logic signed [TIME_W-1:0] decode_post_time;
	} req_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] estimate;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// one row broadcast to every cell of the chain
	typedef struct packed {
		logic [NUM_CURVES-1:0] en;
		logic [SIZE_W-1:0] size;
		logic [NUM_CURVES-1:0][TIME_W-1:0] times;
	} load_t;
endpackage

FILE: sv/clpl_cell.sv
module clpl_cell import clpl_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int IDX = 0,
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input logic clk,
	input load_t ld,
	input logic [NUM_CURVES-1:0][CW-1:0] counts,
	input logic [NUM_CURVES-1:0][SIZE_W-1:0] prev_sz,
	input logic [NUM_CURVES-1:0][TIME_W-1:0] prev_tm,
	output logic [NUM_CURVES-1:0][SIZE_W-1:0] sz,
	output logic [NUM_CURVES-1:0][TIME_W-1:0] tm
);
	logic [NUM_CURVES-1:0][SIZE_W-1:0] sz_q;
	logic [NUM_CURVES-1:0][TIME_W-1:0] tm_q;
	logic [NUM_CURVES-1:0] take_new, take_prev;

	always_comb begin
		logic left_le, below, at;
		for (int c = 0; c < NUM_CURVES; c++) begin
			// new point lands here when the left neighbor is not above it
			left_le = (IDX == 0) ? 1'b1 : (prev_sz[c] <= ld.size);
			below = CW'(IDX) < counts[c];
			at = CW'(IDX) == counts[c];
			take_new[c] = ld.en[c] && left_le && (at || (below && sz_q[c] > ld.size));
			take_prev[c] = ld.en[c] && !left_le && (at || (below && sz_q[c] > ld.size));
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CURVES; c++) begin
			if (take_new[c]) begin
				sz_q[c] <= ld.size;
				tm_q[c] <= ld.times[c];
			end else if (take_prev[c]) begin
				sz_q[c] <= prev_sz[c];
				tm_q[c] <= prev_tm[c];
			end
		end
	end

	assign sz = sz_q;
	assign tm = tm_q;
endmodule

FILE: sv/clpl_div.sv
module clpl_div import clpl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [PROD_W-1:0] num,
	input logic [SIZE_W-1:0] den,
	output logic done,
	output logic signed [PROD_W-1:0] quo
);
	localparam int NCW = $clog2(PROD_W + 1);

	logic run_q, done_q, neg_q;
	logic [NCW-1:0] cnt_q;
	logic [PROD_W-1:0] mag_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W:0] trial;
	logic fits;

	assign trial = {rem_q, mag_q[PROD_W-1]};
	assign fits = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= NCW'(PROD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NCW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division on the magnitude, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[PROD_W-1];
			mag_q <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? SIZE_W'(trial - {1'b0, den}) : trial[SIZE_W-1:0];
			mag_q <= {mag_q[PROD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

FILE: sv/clamped_piecewise_linear_curves.sv
// Six clamped piecewise-linear curves held in a chain of point cells.
// req channel (req_valid/req_stall/req): mode 0 loads one row, each present
// duration is inserted into its curve after equal batch sizes; mode 1
// queries the curve named by curve_select at req_size.
// rsp channel (rsp_valid/rsp_stall/rsp): exactly one beat per request with
// the Q16.16 estimate and a status (ok, empty curve, point dropped).
// One request is in work at a time; req_stall is high until its result
// has moved into the output register.
// Load: all cells shift in parallel in the accept cycle; rsp_valid rises
// once S_DONE has moved the result into the output register.
// Query: S_SEL picks the bracketing points across the chain, S_MUL decides
// or multiplies, then the serial divider gives one quotient bit a cycle;
// clamped or exact-match queries skip the divider, empty ones go to S_DONE.
// A new request is taken the cycle after the result enters the output register.
// Reset empties all curves (counts go to zero) and drops any pending beat.
// A stalled rsp beat holds; the next result waits in the engine until
// the output register frees.
module clamped_piecewise_linear_curves import clpl_pkg::*; #(
	parameter int MAX_POINTS = DEF_MAX_POINTS,
	parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [TIME_W-1:0] ABSENT = {TIME_W{1'b1}} << TIME_FRAC_BITS;

	state_t state_q, state_d;
	logic [NUM_CURVES-1:0][CW-1:0] counts_q;
	logic [SIZE_W-1:0] q_q, ls_q, rs_q, lasts_q;
	logic [TIME_W-1:0] lt_q, rt_q, lastt_q, res_q;
	logic [SEL_W-1:0] sel_q;
	logic has_r_q, r0_q, div_start_q;
	logic [STATUS_W-1:0] status_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SIZE_W-1:0] den_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept, out_free, div_done;
	logic signed [PROD_W-1:0] quo;
	logic [NUM_CURVES-1:0][TIME_W-1:0] row;
	logic [NUM_CURVES-1:0] present, full;
	logic q_empty;
	load_t ld;

	logic [NUM_CURVES-1:0][SIZE_W-1:0] csz [MAX_POINTS+1];
	logic [NUM_CURVES-1:0][TIME_W-1:0] ctm [MAX_POINTS+1];

	assign accept = req_valid && !req_stall;
	assign req_stall = state_q != S_IDLE;
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign row = {req.decode_post_time, req.decode_proc_time, req.decode_pre_time,
		req.prefill_post_time, req.prefill_proc_time, req.prefill_pre_time};

	always_comb begin
		q_empty = req.curve_select >= SEL_W'(NUM_CURVES);
		for (int c = 0; c < NUM_CURVES; c++) begin
			present[c] = row[c] != ABSENT;
			full[c] = present[c] && counts_q[c] == CW'(MAX_POINTS);
			if (req.curve_select == SEL_W'(c) && counts_q[c] == '0)
				q_empty = 1'b1;
		end
		ld.size = req.req_size;
		ld.times = row;
		ld.en = (accept && req.mode == MODE_LOAD) ? (present & ~full) : '0;
	end

	// the chain: cell i takes its left neighbor's point when a new point is inserted left of it
	assign csz[0] = '0;
	assign ctm[0] = '0;
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		clpl_cell #(.MAX_POINTS(MAX_POINTS), .IDX(i)) u_cell (
			.clk(clk),
			.ld(ld),
			.counts(counts_q),
			.prev_sz(csz[i]),
			.prev_tm(ctm[i]),
			.sz(csz[i+1]),
			.tm(ctm[i+1])
		);
	end

	// pick the first point at or above the size, its left neighbor and the last point
	logic [SIZE_W-1:0] r_s, l_s, e_s;
	logic [TIME_W-1:0] r_t, l_t, e_t;
	logic any_r, first_r;
	always_comb begin
		logic [CW-1:0] n;
		logic [MAX_POINTS-1:0] ge, rhot, ehot;
		n = counts_q[sel_q];
		for (int i = 0; i < MAX_POINTS; i++) begin
			ge[i] = (CW'(i) < n) && (csz[i+1][sel_q] >= q_q);
			ehot[i] = CW'(i) == n - 1'b1;
		end
		for (int i = 0; i < MAX_POINTS; i++)
			rhot[i] = ge[i] && (i == 0 || !ge[(i == 0) ? 0 : i - 1]);
		r_s = '0; r_t = '0; l_s = '0; l_t = '0; e_s = '0; e_t = '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			r_s |= rhot[i] ? csz[i+1][sel_q] : '0;
			r_t |= rhot[i] ? ctm[i+1][sel_q] : '0;
			l_s |= rhot[i] ? csz[i][sel_q] : '0;
			l_t |= rhot[i] ? ctm[i][sel_q] : '0;
			e_s |= ehot[i] ? csz[i+1][sel_q] : '0;
			e_t |= ehot[i] ? ctm[i+1][sel_q] : '0;
		end
		any_r = |rhot;
		first_r = rhot[0];
	end

	logic [SIZE_W-1:0] dq;
	logic signed [TIME_W:0] dt;
	assign dq = q_q - ls_q;
	assign dt = $signed({rt_q[TIME_W-1], rt_q}) - $signed({lt_q[TIME_W-1], lt_q});

	clpl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start_q),
		.num(prod_q),
		.den(den_q),
		.done(div_done),
		.quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = (req.mode == MODE_LOAD || q_empty) ? S_DONE : S_SEL;
			end
			S_SEL: state_d = S_MUL;
			S_MUL: begin
				if (!has_r_q || lasts_q <= q_q || r0_q || rs_q == q_q)
					state_d = S_DONE;
				else
					state_d = S_DIV;
			end
			S_DIV: begin
				if (div_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
			rsp_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			for (int c = 0; c < NUM_CURVES; c++)
				if (ld.en[c])
					counts_q[c] <= counts_q[c] + 1'b1;
			if (state_q == S_MUL && state_d == S_DIV)
				div_start_q <= 1'b1;
			if (state_q == S_DONE && out_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q <= req.req_size;
				sel_q <= req.curve_select;
				res_q <= '0;
				if (req.mode == MODE_LOAD)
					status_q <= (|full) ? ST_FULL : ST_OK;
				else
					status_q <= q_empty ? ST_EMPTY : ST_OK;
			end
			S_SEL: begin
				rs_q <= r_s;
				rt_q <= r_t;
				ls_q <= l_s;
				lt_q <= l_t;
				lasts_q <= e_s;
				lastt_q <= e_t;
				has_r_q <= any_r;
				r0_q <= first_r;
			end
			S_MUL: begin
				// at or below the first point wins over the upper clamp
				if (r0_q)
					res_q <= rt_q;
				else if (!has_r_q || lasts_q <= q_q)
					res_q <= lastt_q;
				else
					res_q <= rt_q;
				prod_q <= $signed({1'b0, dq}) * dt;
				den_q <= rs_q - ls_q;
			end
			S_DIV: begin
				if (div_done)
					res_q <= lt_q + quo[TIME_W-1:0];
			end
			S_DONE: begin
				if (out_free) begin
					rsp_q.estimate <= res_q;
					rsp_q.status <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule

FILE: sv/clpl_checker.sv
`include "assert_macros.svh"

module clpl_checker import clpl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
	`ASSERT_CLK(a_req_hold, clk, arst_n, req_valid && req_stall |=> req_valid && $stable(req))
	`ASSERT_NEVER(a_status_code, clk, arst_n, rsp_valid && rsp.status == 2'd3)
	`ASSERT_CLK(a_empty_zero, clk, arst_n, rsp_valid && rsp.status == ST_EMPTY |-> rsp.estimate == '0)
	`ASSERT_CLK(a_load_zero, clk, arst_n, rsp_valid && rsp.status == ST_FULL |-> rsp.estimate == '0)
endmodule

bind clamped_piecewise_linear_curves clpl_checker u_clpl_checker (.*);
